### src/bxq_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the box overlap query block: request kinds,
// register indexes and the fixed field widths of the stream items.
// No dependencies.
package bxq_pkg;

  localparam int IDX_W   = 10;
  localparam int FIELD_W = 32;
  localparam int COLOR_W = 2;
  localparam int REQ_W   = 2;
  localparam int RANK_W  = 2;
  localparam int MASK_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_AXES   = 3;

  localparam int IN_DATA_W  = 208;
  localparam int OUT_DATA_W = 16;

  typedef logic [REQ_W-1:0] req_t;

  localparam req_t REQ_WRITE = 2'd0;
  localparam req_t REQ_QUERY = 2'd1;
  localparam req_t REQ_TEST  = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_RANK        = 2'd0;
  localparam cfg_idx_t REG_USE_FILTER  = 2'd1;
  localparam cfg_idx_t REG_COLOR_MASK  = 2'd2;

  localparam logic [RANK_W-1:0] RANK_RESET = 2'd3;
  localparam logic [MASK_W-1:0] MASK_RESET = 16'hFFFF;

endpackage

### src/box_overlap_query.sv
`timescale 1ns / 1ps
// Box overlap query top level: box table, query registers, overlap test
// and output register. Depends on bxq_pkg and bxq_table.
//
// Writes and set-query items change state and give no result; a test item
// reads its entry from the table and its result passes through the registered
// table read and then the output register, where it is held until taken.
// The single read port of the box table sets the rate of one test item per
// cycle; while a finished result waits and the test behind it has nowhere
// to go, no further item is accepted.
module box_overlap_query #(
  parameter int TABLE_DEPTH = 1024,
  parameter int COORD_WIDTH = 32,
  parameter int NUM_COLORS  = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata, lowest bit up: box_index, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z,
  // item_color, zero fill
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bxq_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: req_type
  input  logic [bxq_pkg::REQ_W-1:0]        in_tuser,
  input  logic                             in_tlast,
  // out_tdata, lowest bit up: hit, hit_index, zero fill
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bxq_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bxq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bxq_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int IDXX_W  = ADDR_W + bxq_pkg::IDX_W;
  localparam int XW      = COORD_WIDTH + bxq_pkg::FIELD_W;
  localparam int NCOORD  = 2 * bxq_pkg::NUM_AXES;
  localparam int ENTRY_W = NCOORD * COORD_WIDTH + bxq_pkg::COLOR_W;
  localparam int SEL_W   = 6;

  // Configuration registers
  logic [bxq_pkg::RANK_W-1:0] rank_r;
  logic                       use_filter_r;
  logic [bxq_pkg::MASK_W-1:0] mask_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r       <= bxq_pkg::RANK_RESET;
      use_filter_r <= 1'b0;
      mask_r       <= bxq_pkg::MASK_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bxq_pkg::REG_RANK:       rank_r       <= cfg_data[bxq_pkg::RANK_W-1:0];
        bxq_pkg::REG_USE_FILTER: use_filter_r <= cfg_data[0];
        bxq_pkg::REG_COLOR_MASK: mask_r       <= cfg_data[bxq_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Input decode
  bxq_pkg::req_t               req;
  logic [bxq_pkg::IDX_W-1:0]   in_idx;
  logic [bxq_pkg::COLOR_W-1:0] in_color;
  logic [IDXX_W-1:0]           idx_ext;
  logic                        in_range;
  logic [ADDR_W-1:0]           in_addr;
  logic [XW-1:0]               coord_wide [NCOORD];
  logic [COORD_WIDTH-1:0]      in_coord   [NCOORD];
  logic [ENTRY_W-1:0]          wr_entry;
  logic                        in_acc;

  assign req      = in_tuser;
  assign in_idx   = in_tdata[bxq_pkg::IDX_W-1:0];
  assign in_color = in_tdata[bxq_pkg::IDX_W + NCOORD * bxq_pkg::FIELD_W +: bxq_pkg::COLOR_W];
  assign idx_ext  = IDXX_W'(in_idx);
  assign in_range = idx_ext < IDXX_W'(TABLE_DEPTH);
  assign in_addr  = idx_ext[ADDR_W-1:0];
  assign in_acc   = in_tvalid && in_tready;

  always_comb begin
    for (int k = 0; k < NCOORD; k++) begin
      coord_wide[k] = XW'(in_tdata[bxq_pkg::IDX_W + k * bxq_pkg::FIELD_W +: bxq_pkg::FIELD_W]);
      in_coord[k]   = coord_wide[k][COORD_WIDTH-1:0];
    end
  end

  always_comb begin
    wr_entry = '0;
    for (int k = 0; k < NCOORD; k++) begin
      wr_entry[k * COORD_WIDTH +: COORD_WIDTH] = in_coord[k];
    end
    wr_entry[NCOORD * COORD_WIDTH +: bxq_pkg::COLOR_W] = in_color;
  end

  // Box table
  logic               tbl_wr_en;
  logic               tbl_rd_en;
  logic [ENTRY_W-1:0] rd_entry;

  assign tbl_wr_en = in_acc && (req == bxq_pkg::REQ_WRITE) && in_range;
  assign tbl_rd_en = in_acc && (req == bxq_pkg::REQ_TEST) && in_range;

  bxq_table #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (ENTRY_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (in_addr),
    .wr_data (wr_entry),
    .rd_en   (tbl_rd_en),
    .rd_addr (in_addr),
    .rd_data (rd_entry)
  );

  // Query registers
  logic signed [COORD_WIDTH-1:0] q_lo_r [bxq_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0] q_hi_r [bxq_pkg::NUM_AXES];
  logic [bxq_pkg::COLOR_W-1:0]   q_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < bxq_pkg::NUM_AXES; k++) begin
        q_lo_r[k] <= '0;
        q_hi_r[k] <= '0;
      end
      q_color_r <= '0;
    end else if (in_acc && (req == bxq_pkg::REQ_QUERY)) begin
      for (int k = 0; k < bxq_pkg::NUM_AXES; k++) begin
        q_lo_r[k] <= in_coord[k];
        q_hi_r[k] <= in_coord[bxq_pkg::NUM_AXES + k];
      end
      q_color_r <= in_color;
    end
  end

  // Read stage
  logic                      s1_vld_r;
  logic                      s1_vld_nxt;
  logic                      s1_inr_r;
  logic [bxq_pkg::IDX_W-1:0] s1_idx_r;
  logic                      s1_last_r;
  logic                      s1_adv;

  logic                      out_vld_r;
  logic                      out_vld_nxt;
  logic                      out_hit_r;
  logic [bxq_pkg::IDX_W-1:0] out_idx_r;
  logic                      out_last_r;

  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    priority if (in_acc) begin
      s1_vld_nxt = (req == bxq_pkg::REQ_TEST);
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_inr_r  <= in_range;
      s1_idx_r  <= in_idx;
      s1_last_r <= in_tlast;
    end
  end

  // Overlap test
  logic signed [COORD_WIDTH-1:0] b_lo [bxq_pkg::NUM_AXES];
  logic signed [COORD_WIDTH-1:0] b_hi [bxq_pkg::NUM_AXES];
  logic [bxq_pkg::COLOR_W-1:0]   b_color;
  logic [bxq_pkg::NUM_AXES-1:0]  axis_on;
  logic [bxq_pkg::NUM_AXES-1:0]  axis_ok;
  logic                          not_empty;
  logic [SEL_W-1:0]              pair_sel;
  logic                          pair_ok;
  logic                          hit;

  always_comb begin
    for (int k = 0; k < bxq_pkg::NUM_AXES; k++) begin
      b_lo[k] = rd_entry[k * COORD_WIDTH +: COORD_WIDTH];
      b_hi[k] = rd_entry[(bxq_pkg::NUM_AXES + k) * COORD_WIDTH +: COORD_WIDTH];
    end
  end

  assign b_color = rd_entry[NCOORD * COORD_WIDTH +: bxq_pkg::COLOR_W];

  assign axis_on[0] = 1'b1;
  assign axis_on[1] = rank_r >= 2'd2;
  assign axis_on[2] = rank_r == 2'd3;

  always_comb begin
    for (int k = 0; k < bxq_pkg::NUM_AXES; k++) begin
      axis_ok[k] = !axis_on[k] || !((q_hi_r[k] < b_lo[k]) || (b_hi[k] < q_lo_r[k]));
    end
  end

  assign not_empty = !(q_lo_r[0] > q_hi_r[0]) && !(b_lo[0] > b_hi[0]);
  assign pair_sel  = SEL_W'(q_color_r) * SEL_W'(NUM_COLORS) + SEL_W'(b_color);
  assign pair_ok   = (SEL_W'(q_color_r) < SEL_W'(NUM_COLORS))
                  && (SEL_W'(b_color) < SEL_W'(NUM_COLORS))
                  && (pair_sel < SEL_W'(bxq_pkg::MASK_W))
                  && mask_r[pair_sel[3:0]];
  assign hit = s1_inr_r && not_empty && (&axis_ok) && (!use_filter_r || pair_ok);

  // Output register
  always_comb begin
    out_vld_nxt = out_vld_r;
    priority if (s1_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_hit_r  <= hit;
      out_idx_r  <= s1_idx_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = bxq_pkg::OUT_DATA_W'({out_idx_r, out_hit_r});
  assign out_tlast  = out_last_r;

endmodule

### src/bxq_table.sv
`timescale 1ns / 1ps
// Box table memory: one write port, one read port with registered data.
// Depends on nothing; widths come from the parent.
module bxq_table #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 194
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sim/bxq_checker.sv
`timescale 1ns / 1ps
// Stream checker for box_overlap_query: mirrors the box table, query box and
// registers, predicts each test result and compares it with the output items.
// Depends on bxq_pkg.
module bxq_checker
  import bxq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  req_t                  in_tuser,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [NUM_AXES-1:0][FIELD_W-1:0] lo;
    logic [NUM_AXES-1:0][FIELD_W-1:0] hi;
    logic [COLOR_W-1:0]               color;
  } box_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] index;
    logic             list_end;
  } verdict_t;

  box_t              box_table [1 << IDX_W];
  box_t              query_box;
  logic [RANK_W-1:0] rank_reg;
  logic              filter_on;
  logic [MASK_W-1:0] pair_mask;
  verdict_t          verdict_q [$];
  int                n_fail = 0;

  function automatic box_t item_box(logic [IN_DATA_W-1:0] d);
    box_t b;
    for (int k = 0; k < NUM_AXES; k++) begin
      b.lo[k] = d[IDX_W + FIELD_W*k +: FIELD_W];
      b.hi[k] = d[IDX_W + FIELD_W*(NUM_AXES + k) +: FIELD_W];
    end
    b.color = d[IDX_W + 2*NUM_AXES*FIELD_W +: COLOR_W];
    return b;
  endfunction

  function automatic logic overlap_hit(box_t b);
    int   n_axes;
    logic h;
    n_axes = (rank_reg == '0) ? 1 : int'(rank_reg);
    h = ($signed(query_box.lo[0]) <= $signed(query_box.hi[0])) &&
        ($signed(b.lo[0]) <= $signed(b.hi[0]));
    for (int k = 0; k < NUM_AXES; k++) begin
      if (k < n_axes && ($signed(query_box.hi[k]) < $signed(b.lo[k]) ||
                         $signed(b.hi[k]) < $signed(query_box.lo[k])))
        h = 1'b0;
    end
    if (h && filter_on)
      h = pair_mask[{query_box.color, b.color}];
    return h;
  endfunction

  task automatic flag(string what, verdict_t want, verdict_t got);
    n_fail++;
    if (n_fail <= 10)
      $display("%0t mismatch (%s): expected hit=%0b index=%0d end=%0b, %s",
               $time, what, want.hit, want.index, want.list_end,
               $sformatf("got hit=%0b index=%0d end=%0b",
                         got.hit, got.index, got.list_end));
  endtask

  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (!rst_n) begin
      verdict_q.delete();
      query_box = '0;
      rank_reg  = RANK_RESET;
      filter_on = 1'b0;
      pair_mask = MASK_RESET;
    end else begin
      if (out_tvalid && out_tready) begin
        got.hit      = out_tdata[0];
        got.index    = out_tdata[IDX_W:1];
        got.list_end = out_tlast;
        if (verdict_q.size() == 0) begin
          flag("no result due", '0, got);
        end else begin
          want = verdict_q.pop_front();
          if (got.hit !== want.hit || got.index !== want.index ||
              got.list_end !== want.list_end)
            flag("result", want, got);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RANK:       rank_reg  = cfg_data[RANK_W-1:0];
          REG_USE_FILTER: filter_on = cfg_data[0];
          REG_COLOR_MASK: pair_mask = cfg_data[MASK_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          REQ_WRITE: box_table[in_tdata[IDX_W-1:0]] = item_box(in_tdata);
          REQ_QUERY: query_box = item_box(in_tdata);
          REQ_TEST: begin
            want.hit      = overlap_hit(box_table[in_tdata[IDX_W-1:0]]);
            want.index    = in_tdata[IDX_W-1:0];
            want.list_end = in_tlast;
            verdict_q.push_back(want);
          end
          default: ;
        endcase
      end
    end
    pending    <= verdict_q.size();
    fail_count <= n_fail;
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for box_overlap_query: clock, reset, stimulus, output stalls
// and the verdict. Depends on bxq_pkg, box_overlap_query and bxq_checker.
module tb;
  import bxq_pkg::*;

  localparam int       WATCHDOG_LIMIT = 2000;
  localparam int       HOLD_CYCLES    = 200;
  localparam int       NUM_PHASES     = 13;
  localparam int       PHASE_ITEMS    = 100;
  localparam req_t     REQ_UNUSED     = 2'd3;
  localparam cfg_idx_t REG_SPARE      = 2'd3;
  localparam int       FILL_W         = IN_DATA_W - IDX_W - 2*NUM_AXES*FIELD_W - COLOR_W;

  typedef logic [NUM_AXES-1:0][FIELD_W-1:0] corner_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  req_t                  in_tuser;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;

  logic quiet    = 1'b0;
  logic hold_req = 1'b0;
  int   idle_cycles = 0;
  logic written [1 << IDX_W];
  int   written_list [$];

  box_overlap_query u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  bxq_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: short random stalls, one long hold on request
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic corner_t splat(logic [FIELD_W-1:0] v);
    return {NUM_AXES{v}};
  endfunction

  function automatic void rand_box(output corner_t lo, output corner_t hi);
    int                 mode;
    int                 c;
    int                 e;
    logic [FIELD_W-1:0] t;
    mode = $urandom_range(0, 9);
    for (int k = 0; k < NUM_AXES; k++) begin
      c = int'($urandom_range(0, 6000)) - 3000;
      e = $urandom_range(0, 2000);
      lo[k] = ((c - e) <<< 12) - int'($urandom_range(0, 4095));
      hi[k] = ((c + e) <<< 12) + int'($urandom_range(0, 4095));
      if (mode == 0) begin
        lo[k] = $urandom;
        hi[k] = $urandom;
      end else if (mode == 1) begin
        if ($urandom_range(0, 1)) lo[k] = 32'h8000_0000;
        if ($urandom_range(0, 1)) hi[k] = 32'h7FFF_FFFF;
      end
    end
    // make the box empty on axis 0
    if (mode == 2) begin
      t     = lo[0];
      lo[0] = hi[0];
      hi[0] = t;
    end
  endfunction

  function automatic logic [IDX_W-1:0] pick_written();
    return IDX_W'(written_list[$urandom_range(0, written_list.size() - 1)]);
  endfunction

  task automatic send_item(req_t req, logic [IDX_W-1:0] idx, corner_t lo, corner_t hi,
                           logic [COLOR_W-1:0] color, logic last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tlast  <= last;
    in_tdata  <= {{FILL_W{1'b0}}, color, hi, lo, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (req == REQ_WRITE && !written[idx]) begin
      written[idx] = 1'b1;
      written_list.push_back(idx);
    end
  endtask

  task automatic send_test(logic [IDX_W-1:0] idx, logic last);
    send_item(REQ_TEST, idx, {$urandom, $urandom, $urandom}, {$urandom, $urandom, $urandom},
              COLOR_W'($urandom), last);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_regs(logic [RANK_W-1:0] rank_val, logic filter_val,
                            logic [MASK_W-1:0] mask_val);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[RANK_W-1:0] = rank_val;
    cfg_write(REG_RANK, d);
    d = CFG_DATA_W'($urandom);
    d[0] = filter_val;
    cfg_write(REG_USE_FILTER, d);
    cfg_write(REG_COLOR_MASK, mask_val);
    cfg_valid <= 1'b0;
  endtask

  // drain all results, then let the pipeline go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_lists(int n_items);
    int      sent;
    int      pick;
    int      n_tests;
    corner_t lo;
    corner_t hi;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 19);
      if (pick < 5 || written_list.size() == 0) begin
        repeat ($urandom_range(1, 4)) begin
          rand_box(lo, hi);
          send_item(REQ_WRITE, $urandom_range(0, 1) ? pick_written() : IDX_W'($urandom),
                    lo, hi, COLOR_W'($urandom), 1'($urandom));
          sent++;
        end
      end else if (pick < 17) begin
        rand_box(lo, hi);
        send_item(REQ_QUERY, IDX_W'($urandom), lo, hi, COLOR_W'($urandom), 1'($urandom));
        sent++;
        n_tests = $urandom_range(1, 8);
        for (int t = 1; t <= n_tests; t++) begin
          send_test(pick_written(), t == n_tests);
          sent++;
        end
      end else if (pick < 19) begin
        // broken list: tests against the old query with random end marks
        repeat ($urandom_range(1, 3)) begin
          send_test(pick_written(), 1'($urandom));
          sent++;
        end
      end else begin
        send_item(REQ_UNUSED, IDX_W'($urandom), {$urandom, $urandom, $urandom},
                  {$urandom, $urandom, $urandom}, COLOR_W'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_WRITE;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_RANK;
    cfg_data  <= '0;
    for (int i = 0; i < (1 << IDX_W); i++) written[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cfg_write(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;

    send_item(REQ_WRITE, 10'd0, splat(-100), splat(100), 2'd1, 1'b0);
    send_item(REQ_WRITE, 10'd1023, splat(100), splat(200), 2'd2, 1'b1);
    send_item(REQ_WRITE, 10'd512, splat(32'h8000_0000), splat(32'h7FFF_FFFF), 2'd3, 1'b0);
    send_item(REQ_WRITE, 10'd5, {32'h8000_0000, 32'h8000_0000, FIELD_W'(10)},
              {32'h7FFF_FFFF, 32'h7FFF_FFFF, FIELD_W'(-10)}, 2'd0, 1'b0);
    send_item(REQ_WRITE, 10'd7, {FIELD_W'(1000), FIELD_W'(1000), FIELD_W'(-50)},
              {FIELD_W'(2000), FIELD_W'(2000), FIELD_W'(50)}, 2'd0, 1'b0);
    send_item(REQ_WRITE, 10'd8, splat(-5000), splat(5000), 2'd3, 1'b0);

    send_item(REQ_QUERY, 10'd0, splat(-100), splat(100), 2'd1, 1'b0);
    send_test(10'd0, 1'b0);
    send_test(10'd1023, 1'b0);
    send_test(10'd512, 1'b0);
    send_test(10'd5, 1'b0);
    send_test(10'd7, 1'b0);
    send_test(10'd8, 1'b1);

    send_item(REQ_QUERY, 10'd1023, splat(1), splat(0), 2'd2, 1'b0);
    send_test(10'd512, 1'b1);

    send_item(REQ_UNUSED, 10'd0, splat(0), splat(0), 2'd0, 1'b1);

    send_item(REQ_QUERY, 10'd512, splat(32'h8000_0000), splat(32'h7FFF_FFFF), 2'd3, 1'b1);
    send_test(10'd0, 1'b0);
    send_test(10'd1023, 1'b0);
    send_test(10'd5, 1'b0);
    send_test(10'd7, 1'b1);

    send_item(REQ_QUERY, 10'd7, splat(200), splat(300), 2'd0, 1'b0);
    send_test(10'd1023, 1'b0);
    send_test(10'd0, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0:       write_regs(2'd1, 1'b0, 16'hFFFF);
        1:       write_regs(2'd2, 1'b1, 16'h0000);
        2:       write_regs(2'd0, 1'b1, 16'hFFFF);
        3:       write_regs(2'd3, 1'b1, MASK_W'($urandom));
        default: write_regs(RANK_W'($urandom), 1'($urandom),
                            ($urandom_range(0, 3) == 0) ? 16'h0000 : MASK_W'($urandom));
      endcase
      if (p == 4) hold_req = 1'b1;
      if (p >= NUM_PHASES - 2) quiet = 1'b1;
      run_lists(PHASE_ITEMS);
    end

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
